/* sv/sit_pkg.sv */
// shared types, constants and helpers for the segment intersection test
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int OUT_TDATA_W     = 8;

    typedef enum logic [2:0] {
        ORI_ON     = 3'd0,
        ORI_CCW    = 3'd1,
        ORI_CW     = 3'd2,
        ORI_BEHIND = 3'd3,
        ORI_BEYOND = 3'd4
    } t_orient;

    // positive codes: counter-clockwise and behind the start
    function automatic logic orient_pos(input t_orient o);
        logic r;
        r = (o == ORI_CCW) || (o == ORI_BEHIND);
        return r;
    endfunction

    // product of two codes at most zero
    function automatic logic codes_straddle(input t_orient a, input t_orient b);
        logic r;
        r = (a == ORI_ON) || (b == ORI_ON) || (orient_pos(a) != orient_pos(b));
        return r;
    endfunction

endpackage

/* sv/sit_orient.sv */
// orientation unit: classifies point r against directed segment p->q
module sit_orient #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_qx,
    input  logic signed [COORD_WIDTH-1:0] i_qy,
    input  logic signed [COORD_WIDTH-1:0] i_rx,
    input  logic signed [COORD_WIDTH-1:0] i_ry,
    output sit_pkg::t_orient              o_code
);
    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int SW = 2 * COORD_WIDTH + 3;

    logic signed [DW-1:0] ux, uy, vx, vy;
    logic signed [PW-1:0] n_uxvy, n_uyvx, n_uxvx, n_uyvy, n_uxux, n_uyuy, n_vxvx, n_vyvy;
    logic signed [PW-1:0] r_uxvy, r_uyvx, r_uxvx, r_uyvy, r_uxux, r_uyuy, r_vxvx, r_vyvy;
    logic signed [SW-1:0] cr, dt, lu, lv;

    assign ux = $signed({i_qx[COORD_WIDTH-1], i_qx}) - $signed({i_px[COORD_WIDTH-1], i_px});
    assign uy = $signed({i_qy[COORD_WIDTH-1], i_qy}) - $signed({i_py[COORD_WIDTH-1], i_py});
    assign vx = $signed({i_rx[COORD_WIDTH-1], i_rx}) - $signed({i_px[COORD_WIDTH-1], i_px});
    assign vy = $signed({i_ry[COORD_WIDTH-1], i_ry}) - $signed({i_py[COORD_WIDTH-1], i_py});

    assign n_uxvy = ux * vy;
    assign n_uyvx = uy * vx;
    assign n_uxvx = ux * vx;
    assign n_uyvy = uy * vy;
    assign n_uxux = ux * ux;
    assign n_uyuy = uy * uy;
    assign n_vxvx = vx * vx;
    assign n_vyvy = vy * vy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_uxvy <= n_uxvy;
            r_uyvx <= n_uyvx;
            r_uxvx <= n_uxvx;
            r_uyvy <= n_uyvy;
            r_uxux <= n_uxux;
            r_uyuy <= n_uyuy;
            r_vxvx <= n_vxvx;
            r_vyvy <= n_vyvy;
        end
    end

    assign cr = $signed({r_uxvy[PW-1], r_uxvy}) - $signed({r_uyvx[PW-1], r_uyvx});
    assign dt = $signed({r_uxvx[PW-1], r_uxvx}) + $signed({r_uyvy[PW-1], r_uyvy});
    assign lu = $signed({r_uxux[PW-1], r_uxux}) + $signed({r_uyuy[PW-1], r_uyuy});
    assign lv = $signed({r_vxvx[PW-1], r_vxvx}) + $signed({r_vyvy[PW-1], r_vyvy});

    always_comb begin
        priority if (cr > 0) begin
            o_code = ORI_CCW;
        end else if (cr < 0) begin
            o_code = ORI_CW;
        end else if (dt < 0) begin
            o_code = ORI_BEHIND;
        end else if (lu < lv) begin
            o_code = ORI_BEYOND;
        end else begin
            o_code = ORI_ON;
        end
    end

endmodule

/* sv/segment_intersection_test.sv */
// segment intersection test top level: stream in two segments, stream out a hit flag
//
// Each input transfer carries the end points A, B of one segment and C, D of the other as
// signed COORD_WIDTH-bit coordinates; one output transfer follows with bit 0 set when the
// segments share at least one point, touching and collinear overlap included. The block
// takes one transfer every cycle; each item passes the input, product and result registers
// in turn before the result is presented. Four orientation units work in parallel, each
// with eight exact multipliers of COORD_WIDTH+1 bits; there is no state between items.
// When the result register is full and not taken the whole pipeline holds.
module segment_intersection_test #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [8*COORD_WIDTH-1:0]         i_s_axis_tdata,  // ax, ay, bx, by, cx, cy, dx, dy
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [sit_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata   // intersects, zero pad
);
    import sit_pkg::*;

    localparam int W = COORD_WIDTH;

    logic                r_s0_valid, r_s1_valid, r_out_valid;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;
    logic                r_hit;
    logic                en, n_hit;
    t_orient             o1, o2, o3, o4;

    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid  <= i_s_axis_tvalid;
            r_s1_valid  <= r_s0_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax  <= i_s_axis_tdata[0*W +: W];
            r_ay  <= i_s_axis_tdata[1*W +: W];
            r_bx  <= i_s_axis_tdata[2*W +: W];
            r_by  <= i_s_axis_tdata[3*W +: W];
            r_cx  <= i_s_axis_tdata[4*W +: W];
            r_cy  <= i_s_axis_tdata[5*W +: W];
            r_dx  <= i_s_axis_tdata[6*W +: W];
            r_dy  <= i_s_axis_tdata[7*W +: W];
            r_hit <= n_hit;
        end
    end

    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_abc (
        .i_clk(i_clk), .i_en(en),
        .i_px(r_ax), .i_py(r_ay), .i_qx(r_bx), .i_qy(r_by), .i_rx(r_cx), .i_ry(r_cy),
        .o_code(o1)
    );

    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_abd (
        .i_clk(i_clk), .i_en(en),
        .i_px(r_ax), .i_py(r_ay), .i_qx(r_bx), .i_qy(r_by), .i_rx(r_dx), .i_ry(r_dy),
        .o_code(o2)
    );

    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_cda (
        .i_clk(i_clk), .i_en(en),
        .i_px(r_cx), .i_py(r_cy), .i_qx(r_dx), .i_qy(r_dy), .i_rx(r_ax), .i_ry(r_ay),
        .o_code(o3)
    );

    sit_orient #(.COORD_WIDTH(COORD_WIDTH)) u_cdb (
        .i_clk(i_clk), .i_en(en),
        .i_px(r_cx), .i_py(r_cy), .i_qx(r_dx), .i_qy(r_dy), .i_rx(r_bx), .i_ry(r_by),
        .o_code(o4)
    );

    assign n_hit = codes_straddle(o1, o2) && codes_straddle(o3, o4);

endmodule

/* verif/tb_segment_intersection_test.sv */
// testbench for the segment intersection test: directed table plus random segment pairs
`timescale 1ns / 1ps

module tb_segment_intersection_test;
    import sit_pkg::*;

    localparam int COORD_W        = COORD_WIDTH_DEF;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 830;
    localparam int MAX_GAP        = 6;
    localparam int LONG_HOLD      = 120;
    localparam int HOLD_AT_ITEM   = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIRECTED_ROWS  = 24;
    localparam int PREDICT        = -1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // ax lands in the lowest bits, as on the input tdata
    typedef struct packed {
        t_coord dy, dx, cy, cx, by, bx, ay, ax;
    } t_seg_pair;

    typedef struct {
        logic hit;
        int   item_no;
    } t_pending_hit;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [8*COORD_W-1:0]   i_s_axis_tdata;  // ax, ay, bx, by, cx, cy, dx, dy
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;  // intersects, zero pad

    t_pending_hit hits_due[$];
    t_pending_hit due;
    int           items_in;
    int           mismatches;
    int           idle_cycles;
    logic         src_quiet;
    logic         sink_quiet;
    logic         sink_hold_req;

    // ax ay bx by cx cy dx dy, then the hit flag or PREDICT
    int dir_tab [DIRECTED_ROWS][9] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 1},
        '{-10, -10, 10, 10, -10, 10, 10, -10, 1},
        '{0, 0, 10, 0, 0, 5, 10, 5, 0},
        '{0, 0, 10, 0, 5, 0, 15, 0, 1},
        '{0, 0, 10, 0, 20, 0, 30, 0, 0},
        '{0, 0, 10, 0, 10, 0, 20, 0, 1},
        '{0, 0, 10, 0, 5, 0, 5, 10, 1},
        '{0, 0, 10, 0, 11, -5, 11, 5, 0},
        '{0, 0, 10, 0, -5, 0, -1, 0, 0},
        '{0, 0, 10, 0, -5, 0, 20, 0, 1},
        '{10, 0, 0, 0, 3, 0, 7, 0, PREDICT},
        '{5, 5, 5, 5, 0, 0, 10, 10, PREDICT},
        '{0, 0, 10, 10, 5, 5, 5, 5, PREDICT},
        '{3, 4, 3, 4, 3, 4, 3, 4, 1},
        '{1, 2, 1, 2, 7, 7, 7, 7, PREDICT},
        '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1},
        '{-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1},
        '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0},
        '{-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767, 0},
        '{-32768, 32767, 32767, -32768, 0, 0, 32767, 32767, PREDICT},
        '{0, 0, 5, 5, 5, 5, 10, 0, 1},
        '{0, 0, 4, 4, 1, 1, 3, 3, 1}
    };

    segment_intersection_test #(
        .COORD_WIDTH(COORD_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic t_orient orient_of(input longint px, input longint py,
                                          input longint qx, input longint qy,
                                          input longint rx, input longint ry);
        longint ux, uy, vx, vy, cr;
        ux = qx - px;
        uy = qy - py;
        vx = rx - px;
        vy = ry - py;
        cr = ux * vy - uy * vx;
        if (cr > 0) return ORI_CCW;
        if (cr < 0) return ORI_CW;
        if (ux * vx + uy * vy < 0) return ORI_BEHIND;
        if (ux * ux + uy * uy < vx * vx + vy * vy) return ORI_BEYOND;
        return ORI_ON;
    endfunction

    function automatic int orient_sign(input t_orient o);
        case (o)
            ORI_CCW, ORI_BEHIND: return 1;
            ORI_CW, ORI_BEYOND:  return -1;
            default:             return 0;
        endcase
    endfunction

    function automatic logic predict_hit(input t_seg_pair p);
        int s1, s2, s3, s4;
        s1 = orient_sign(orient_of(p.ax, p.ay, p.bx, p.by, p.cx, p.cy));
        s2 = orient_sign(orient_of(p.ax, p.ay, p.bx, p.by, p.dx, p.dy));
        s3 = orient_sign(orient_of(p.cx, p.cy, p.dx, p.dy, p.ax, p.ay));
        s4 = orient_sign(orient_of(p.cx, p.cy, p.dx, p.dy, p.bx, p.by));
        return (s1 * s2 <= 0) && (s3 * s4 <= 0);
    endfunction

    function automatic t_coord small_coord();
        return t_coord'(int'($urandom_range(0, 16)) - 8);
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(0, 7))
            0:       return t_coord'(-32768);
            1:       return t_coord'(32767);
            2:       return t_coord'(-32767);
            3:       return t_coord'(32766);
            4:       return t_coord'(0);
            5:       return t_coord'(-1);
            6:       return t_coord'(1);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_seg_pair random_pair();
        t_coord c [8];
        int     x0, y0, ux, uy, t, k, j;
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int i = 0; i < 8; i++) c[i] = t_coord'($urandom);
            end
            2, 3, 4: begin
                for (int i = 0; i < 8; i++) c[i] = small_coord();
            end
            5, 6: begin
                // all four points on one line
                x0 = int'($urandom_range(0, 60000)) - 30000;
                y0 = int'($urandom_range(0, 60000)) - 30000;
                ux = int'($urandom_range(0, 8)) - 4;
                uy = int'($urandom_range(0, 8)) - 4;
                for (int i = 0; i < 4; i++) begin
                    t = int'($urandom_range(0, 12)) - 6;
                    c[2*i]   = t_coord'(x0 + t * ux);
                    c[2*i+1] = t_coord'(y0 + t * uy);
                end
            end
            7: begin
                // shared end point
                for (int i = 0; i < 8; i++) c[i] = small_coord();
                k = 2 * int'($urandom_range(0, 1));
                j = 4 + 2 * int'($urandom_range(0, 1));
                c[j]   = c[k];
                c[j+1] = c[k+1];
            end
            8: begin
                // one or both segments collapsed to a point
                for (int i = 0; i < 8; i++) c[i] = small_coord();
                k = $urandom_range(0, 2);
                if (k != 1) begin
                    c[2] = c[0];
                    c[3] = c[1];
                end
                if (k != 0) begin
                    c[6] = c[4];
                    c[7] = c[5];
                end
            end
            default: begin
                for (int i = 0; i < 8; i++) c[i] = edge_coord();
            end
        endcase
        return {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
    endfunction

    // entered at a falling edge, returns at the falling edge after the transfer
    task automatic send_pair(input t_seg_pair p, input int typed_hit);
        int           gap;
        t_pending_hit entry;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        entry.hit     = (typed_hit == PREDICT) ? predict_hit(p) : typed_hit[0];
        entry.item_no = items_in;
        hits_due.push_back(entry);
        items_in++;
        @(negedge i_clk);
    endtask

    initial begin
        t_seg_pair p;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        items_in        = 0;
        mismatches      = 0;
        src_quiet       = 1'b0;
        sink_hold_req   = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            p = {t_coord'(dir_tab[row][7]), t_coord'(dir_tab[row][6]),
                 t_coord'(dir_tab[row][5]), t_coord'(dir_tab[row][4]),
                 t_coord'(dir_tab[row][3]), t_coord'(dir_tab[row][2]),
                 t_coord'(dir_tab[row][1]), t_coord'(dir_tab[row][0])};
            send_pair(p, dir_tab[row][8]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) src_quiet = ($urandom_range(0, 3) == 0);
            if (n == HOLD_AT_ITEM) sink_hold_req = 1'b1;
            send_pair(random_pair(), PREDICT);
        end
        i_s_axis_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random hold-offs, one long hold on request
    initial begin
        int wait_cycles;
        int taken;
        i_m_axis_tready = 1'b0;
        sink_quiet      = 1'b0;
        taken           = 0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
            if (sink_hold_req) begin
                wait_cycles   = LONG_HOLD;
                sink_hold_req = 1'b0;
            end else begin
                wait_cycles = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (wait_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (hits_due.size() == 0) begin
                $display("%0t: result transfer with none expected, got %0h",
                         $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                due = hits_due.pop_front();
                if (o_m_axis_tdata !== {{(OUT_TDATA_W-1){1'b0}}, due.hit}) begin
                    $display("%0t: item %0d intersects mismatch, expected %0h, got %0h",
                             $time, due.item_no, due.hit, o_m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
